FILE: hdl/sbpf_pkg.sv
// Shared types and constants for the servo bus packet framer.
`timescale 1ns / 1ps
package sbpf_pkg;

  localparam logic [1:0] ReqPos   = 2'd0;
  localparam logic [1:0] ReqWheel = 2'd1;
  localparam logic [1:0] ReqMode  = 2'd2;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgBroadcastId  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncWrCode   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWriteCode    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGoalPosAddr  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgEntryDataLen = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgModeRegAddr  = 3'd5;

  localparam logic [7:0] RstBroadcastId  = 8'd254;
  localparam logic [7:0] RstSyncWrCode   = 8'd131;
  localparam logic [7:0] RstWriteCode    = 8'd3;
  localparam logic [7:0] RstGoalPosAddr  = 8'd30;
  localparam logic [7:0] RstEntryDataLen = 8'd4;
  localparam logic [7:0] RstModeRegAddr  = 8'd0;

  localparam logic [7:0] HdrByte     = 8'hFF;
  localparam logic [7:0] ModeLength  = 8'h04;
  localparam logic [7:0] ModeValue   = 8'h00;
  localparam logic [7:0] WheelPosLo  = 8'h00;
  localparam logic [7:0] WheelPosHi  = 8'h02;
  localparam logic signed [15:0] ClampMax = 16'sd1023;
  localparam logic signed [15:0] ClampMin = -16'sd1023;
  localparam logic [15:0] NegFlag    = 16'd1024;

  localparam int CmdQDepth = 2;

  typedef struct packed {
    logic [7:0] broadcast_id;
    logic [7:0] sync_write_code;
    logic [7:0] write_code;
    logic [7:0] goal_position_address;
    logic [7:0] entry_data_length;
    logic [7:0] mode_register_address;
  } cfg_t;

  typedef struct packed {
    logic       is_mode;
    logic       hdr;
    logic       last;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] plo;
    logic [7:0] phi;
    logic [7:0] slo;
    logic [7:0] shi;
  } cmd_t;

endpackage

FILE: hdl/sbpf_front.sv
// Front end: classifies requests, tracks packet state, builds byte commands.
`timescale 1ns / 1ps
module sbpf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_servo_id,
  input  logic [5:0]          in_entry_count,
  input  logic signed [15:0]  in_position,
  input  logic signed [15:0]  in_speed,
  output logic                cmd_wr,
  output sbpf_pkg::cmd_t      cmd
);
  import sbpf_pkg::*;

  logic        open_r, open_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [5:0]  cnt;
  logic [5:0]  rem_cur;
  logic        is_entry;
  logic signed [15:0] pclamp, sclamp, wclamp;
  logic [15:0] wmag, sbits;

  assign is_entry = (in_req_type == ReqPos) || (in_req_type == ReqWheel);
  assign cnt      = (in_entry_count == 6'd0) ? 6'd1 : in_entry_count;
  assign rem_cur  = open_r ? rem_r : cnt;

  always_comb begin
    pclamp = (in_position > ClampMax) ? ClampMax : in_position;
    sclamp = (in_speed > ClampMax) ? ClampMax : in_speed;
    wclamp = (in_speed < ClampMin) ? ClampMin : sclamp;
    wmag   = 16'(-wclamp) | NegFlag;
    sbits  = (in_req_type == ReqPos) ? 16'(sclamp)
           : (wclamp[15] ? wmag : 16'(wclamp));
  end

  always_comb begin
    cmd.is_mode = (in_req_type == ReqMode);
    cmd.hdr     = !open_r;
    cmd.last    = (rem_cur == 6'd1);
    cmd.id      = in_servo_id;
    cmd.len     = 8'({cnt, 2'b00}) + 8'(cnt) + 8'd4;
    cmd.plo     = (in_req_type == ReqPos) ? pclamp[7:0] : WheelPosLo;
    cmd.phi     = (in_req_type == ReqPos) ? pclamp[15:8] : WheelPosHi;
    cmd.slo     = sbits[7:0];
    cmd.shi     = sbits[15:8];
  end

  always_comb begin
    cmd_wr   = 1'b0;
    open_nxt = open_r;
    rem_nxt  = rem_r;
    if (accept) begin
      if (is_entry) begin
        cmd_wr   = 1'b1;
        rem_nxt  = rem_cur - 6'd1;
        open_nxt = (rem_cur != 6'd1);
      end else if (in_req_type == ReqMode && !open_r) begin
        cmd_wr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r  <= 6'd0;
    end else begin
      open_r <= open_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

FILE: hdl/sbpf_cmd_fifo.sv
// Short command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
module sbpf_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  sbpf_pkg::cmd_t wr_cmd,
  input  logic           rd_en,
  output sbpf_pkg::cmd_t rd_cmd,
  output logic           q_full,
  output logic           q_empty
);
  import sbpf_pkg::*;

  localparam int PtrW = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;
  localparam int CntW = $clog2(CmdQDepth + 1);

  cmd_t            mem_r [CmdQDepth];
  logic [PtrW-1:0] wptr_r, rptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_wr, do_rd;

  assign q_full  = (cnt_r == CntW'(CmdQDepth));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PtrW'(CmdQDepth - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PtrW'(CmdQDepth - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CntW'(do_wr) - CntW'(do_rd);
    end
  end

endmodule

FILE: hdl/sbpf_back.sv
// Back end: steps through packet bytes, keeps the checksum, drives the output register.
`timescale 1ns / 1ps
module sbpf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sbpf_pkg::cfg_t cfg,
  input  sbpf_pkg::cmd_t q_cmd,
  input  logic           q_empty,
  output logic           q_rd,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_end_of_packet
);
  import sbpf_pkg::*;

  localparam logic [3:0] StFirst   = 4'd0;
  localparam logic [3:0] StSecond  = 4'd1;
  localparam logic [3:0] StId      = 4'd2;
  localparam logic [3:0] StLen     = 4'd3;
  localparam logic [3:0] StInstr   = 4'd4;
  localparam logic [3:0] StAddr    = 4'd5;
  localparam logic [3:0] StData    = 4'd6;
  localparam logic [3:0] StEntId   = 4'd7;
  localparam logic [3:0] StPosLo   = 4'd8;
  localparam logic [3:0] StPosHi   = 4'd9;
  localparam logic [3:0] StSpdLo   = 4'd10;
  localparam logic [3:0] StSpdHi   = 4'd11;
  localparam logic [3:0] StCheck   = 4'd12;

  cmd_t       cmd_r;
  logic       busy_r, busy_nxt;
  logic [3:0] step_r, step_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       oval_r, oval_nxt;
  logic [7:0] obyte_r;
  logic       oeop_r;
  logic       adv, last_step, load;
  logic [7:0] cur_byte;

  assign adv       = busy_r && (!oval_r || pop);
  assign last_step = (step_r == StCheck) ||
                     (step_r == StSpdHi && !cmd_r.is_mode && !cmd_r.last);
  assign load      = !busy_r || (adv && last_step);
  assign q_rd      = load && !q_empty;

  always_comb begin
    unique case (step_r)
      StFirst, StSecond: cur_byte = HdrByte;
      StId:    cur_byte = cmd_r.is_mode ? cmd_r.id : cfg.broadcast_id;
      StLen:   cur_byte = cmd_r.is_mode ? ModeLength : cmd_r.len;
      StInstr: cur_byte = cmd_r.is_mode ? cfg.write_code : cfg.sync_write_code;
      StAddr:  cur_byte = cmd_r.is_mode ? cfg.mode_register_address
                                        : cfg.goal_position_address;
      StData:  cur_byte = cmd_r.is_mode ? ModeValue : cfg.entry_data_length;
      StEntId: cur_byte = cmd_r.id;
      StPosLo: cur_byte = cmd_r.plo;
      StPosHi: cur_byte = cmd_r.phi;
      StSpdLo: cur_byte = cmd_r.slo;
      StSpdHi: cur_byte = cmd_r.shi;
      StCheck: cur_byte = ~sum_r;
      default: cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    sum_nxt  = sum_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    oval_nxt = oval_r && !pop;
    if (adv) begin
      oval_nxt = 1'b1;
      if (step_r == StCheck) begin
        sum_nxt = 8'h00;
      end else if (step_r >= StId) begin
        sum_nxt = sum_r + cur_byte;
      end
      step_nxt = (cmd_r.is_mode && step_r == StData) ? StCheck : step_r + 4'd1;
    end
    if (load) begin
      busy_nxt = !q_empty;
      step_nxt = (q_cmd.is_mode || q_cmd.hdr) ? StFirst : StEntId;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cmd_r <= q_cmd;
    end
    if (adv) begin
      obyte_r <= cur_byte;
      oeop_r  <= (step_r == StCheck);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= StFirst;
      sum_r  <= 8'h00;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      sum_r  <= sum_nxt;
      oval_r <= oval_nxt;
    end
  end

  assign empty             = !oval_r;
  assign out_byte          = obyte_r;
  assign out_end_of_packet = oeop_r;

endmodule

FILE: hdl/servo_bus_packet_framer_top.sv
// Top level of the servo bus packet framer.
//
// Input queue port: one beat per push when full is low. Each beat is a sync
// write entry (position or wheel speed) or a mode write request. The first
// entry of a sync packet brings the seven header bytes; every entry brings
// five bytes; the last entry also brings the checksum. A mode write brings a
// whole eight byte packet. Type three, and a mode write inside an open sync
// packet, produce nothing.
// Output queue port: one byte per beat while empty is low, taken with pop;
// out_end_of_packet marks the checksum byte.
// Path: a taken beat is written into the command queue, loaded into the
// sequencer's command register, and its first byte is then registered
// into the output register. Throughput: the byte sequencer emits one
// byte per cycle while the output is not stalled. A two deep command
// queue lets the input side run ahead.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index at once.
// Reset (rst_n low, synchronous) restores the register defaults, closes any
// open packet and flushes queued work. A stalled output holds its byte and
// the sequencer waits; once the command queue fills, full rises.
`timescale 1ns / 1ps
module servo_bus_packet_framer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   in_req_type,
  input  logic [7:0]                   in_servo_id,
  input  logic [5:0]                   in_entry_count,
  input  logic signed [15:0]           in_position,
  input  logic signed [15:0]           in_speed,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_byte,
  output logic                         out_end_of_packet,
  input  logic                         cfg_wr_en,
  input  logic [sbpf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                   cfg_data
);
  import sbpf_pkg::*;

  cfg_t cfg_r;
  cmd_t f_cmd, q_cmd;
  logic f_wr, q_rd, q_empty, accept;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.broadcast_id          <= RstBroadcastId;
      cfg_r.sync_write_code       <= RstSyncWrCode;
      cfg_r.write_code            <= RstWriteCode;
      cfg_r.goal_position_address <= RstGoalPosAddr;
      cfg_r.entry_data_length     <= RstEntryDataLen;
      cfg_r.mode_register_address <= RstModeRegAddr;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CfgBroadcastId:  cfg_r.broadcast_id          <= cfg_data;
        CfgSyncWrCode:   cfg_r.sync_write_code       <= cfg_data;
        CfgWriteCode:    cfg_r.write_code            <= cfg_data;
        CfgGoalPosAddr:  cfg_r.goal_position_address <= cfg_data;
        CfgEntryDataLen: cfg_r.entry_data_length     <= cfg_data;
        CfgModeRegAddr:  cfg_r.mode_register_address <= cfg_data;
        default: ;
      endcase
    end
  end

  sbpf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_req_type    (in_req_type),
    .in_servo_id    (in_servo_id),
    .in_entry_count (in_entry_count),
    .in_position    (in_position),
    .in_speed       (in_speed),
    .cmd_wr         (f_wr),
    .cmd            (f_cmd)
  );

  sbpf_cmd_fifo u_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_wr),
    .wr_cmd  (f_cmd),
    .rd_en   (q_rd),
    .rd_cmd  (q_cmd),
    .q_full  (full),
    .q_empty (q_empty)
  );

  sbpf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_cmd             (q_cmd),
    .q_empty           (q_empty),
    .q_rd              (q_rd),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_end_of_packet (out_end_of_packet)
  );

endmodule

FILE: hdl/sbpf_checker.sv
// Port-level checks for the servo bus packet framer, bound to the top level.
`timescale 1ns / 1ps
module sbpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_end_of_packet
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queues not cleared by reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_end_of_packet))
    else $error("stalled output beat changed");

  a_next_pkt_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && pop && out_end_of_packet |=> empty || out_byte == 8'hFF)
    else $error("packet does not start with header byte");

  a_eop_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && pop && out_end_of_packet |=> empty || !out_end_of_packet)
    else $error("back-to-back end of packet beats");

endmodule

bind servo_bus_packet_framer_top sbpf_checker u_sbpf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .push              (push),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_byte          (out_byte),
  .out_end_of_packet (out_end_of_packet)
);
